FILE: src/cta_pkg.sv
// ----------------------------------------------------------------------------
// cta_pkg: shared types and constants of the circular three point average
// Sample and position widths, sequence length limit, divide-by-3 reciprocal,
// and the work entry that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package cta_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 4096;
    localparam int POS_BITS    = 12;
    localparam int CNT_BITS    = $clog2(MAX_LEN);

    // Sum of three samples and its magnitude
    localparam int SUM_BITS    = SAMPLE_BITS + 2;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;

    // Divide by 3: (mag * RECIP3) >> RECIP_SHIFT is exact for mag < 2**MAG_BITS
    localparam int RECIP_SHIFT = SAMPLE_BITS + 2;
    localparam int RECIP3      = (2 ** RECIP_SHIFT + 2) / 3;
    localparam int PROD_BITS   = 2 * MAG_BITS;

    // Work queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Result kinds an entry may ask for, one bit each, issued low bit first
    localparam int OP_MID  = 0;  // g[i-1] from older, newer, sample
    localparam int OP_TAIL = 1;  // g[N-1] from newer, sample, first
    localparam int OP_HEAD = 2;  // g[0]   from sample, first, second
    localparam int OP_BITS = 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [SAMPLE_BITS-1:0] older;
        logic signed [SAMPLE_BITS-1:0] newer;
        logic signed [SAMPLE_BITS-1:0] first;
        logic signed [SAMPLE_BITS-1:0] second;
        logic        [POS_BITS-1:0]    pos;
        logic        [OP_BITS-1:0]     ops;
    } t_entry;

endpackage

FILE: src/cta_front.sv
// ----------------------------------------------------------------------------
// cta_front: sample intake and classification
// Holds first, second, older and newer samples and the position count, and
// turns each accepted item into a work entry naming the results it causes.
// ----------------------------------------------------------------------------
module cta_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [cta_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                             i_last_sample,
    input  logic                             i_full,
    output logic                             o_push,
    output cta_pkg::t_entry                  o_entry
);
    import cta_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_LEN - 1);

    logic signed [SAMPLE_BITS-1:0] r_first, r_second, r_older, r_newer;
    logic        [CNT_BITS-1:0]    r_count;
    logic signed [SAMPLE_BITS-1:0] n_first, n_second;
    logic        [CNT_BITS-1:0]    n_count;
    logic                          accept;
    logic                          last;
    logic                          is_zero;
    logic                          is_one;

    assign accept  = i_valid && !i_full;
    assign is_zero = (r_count == '0);
    assign is_one  = (r_count == CNT_BITS'(1));
    assign last    = i_last_sample || (r_count == CNT_LAST);

    // Classify: middle result from third sample on; at the end head, tail if N>1
    always_comb begin
        n_first  = is_zero ? i_sample : r_first;
        n_second = (is_zero || is_one) ? i_sample : r_second;
        n_count  = last ? '0 : r_count + CNT_BITS'(1);

        o_entry.smp          = i_sample;
        o_entry.older        = r_older;
        o_entry.newer        = r_newer;
        o_entry.first        = n_first;
        o_entry.second       = n_second;
        o_entry.pos          = POS_BITS'(r_count);
        o_entry.ops          = '0;
        o_entry.ops[OP_MID]  = !is_zero && !is_one;
        o_entry.ops[OP_TAIL] = last && !is_zero;
        o_entry.ops[OP_HEAD] = last;
    end

    // Drop items that cause no result
    assign o_push = accept && (o_entry.ops != '0);

    // Advance sequence state on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_older  <= '0;
            r_newer  <= '0;
        end else if (accept) begin
            r_count  <= n_count;
            r_first  <= n_first;
            r_second <= n_second;
            r_older  <= r_newer;
            r_newer  <= i_sample;
        end
    end

endmodule

FILE: src/cta_queue.sv
// ----------------------------------------------------------------------------
// cta_queue: work entry queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module cta_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cta_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output cta_pkg::t_entry o_entry
);
    import cta_pkg::*;

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0]   r_fill;
    logic                   do_push, do_pop;

    assign o_full  = (r_fill == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + QCNT_BITS'(1);
                2'b01:   r_fill <= r_fill - QCNT_BITS'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: src/cta_back.sv
// ----------------------------------------------------------------------------
// cta_back: three point mean execution
// Issues the results of the head entry one per cycle unless stalled, forms
// the three sample sum in one stage, divides by 3 by reciprocal multiply in
// the next, and holds the result in the output register.
// ----------------------------------------------------------------------------
module cta_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    input  cta_pkg::t_entry                        i_q_entry,
    output logic                                   o_q_pop,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cta_pkg::SAMPLE_BITS-1:0] o_filtered,
    output logic        [cta_pkg::POS_BITS-1:0]    o_position,
    output logic                                   o_end_of_sequence
);
    import cta_pkg::*;

    localparam logic [MAG_BITS-1:0] RECIP = MAG_BITS'(RECIP3);

    logic [OP_BITS-1:0]            r_done;
    logic [OP_BITS-1:0]            pend, sel, rest;
    logic                          issue;
    logic signed [SAMPLE_BITS-1:0] opa, opb, opc;
    logic        [POS_BITS-1:0]    sel_pos;
    logic                          sel_eos;
    logic signed [SUM_BITS-1:0]    sum;

    logic                          r_s1_valid;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic        [POS_BITS-1:0]    r_s1_pos;
    logic                          r_s1_eos;

    logic                          out_ready, s1_ready;
    logic        [SUM_BITS-1:0]    abs_sum;
    logic        [MAG_BITS-1:0]    mag;
    logic        [PROD_BITS-1:0]   prod;
    logic        [SAMPLE_BITS-1:0] quot;
    logic        [SAMPLE_BITS-1:0] n_filtered;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_filtered;
    logic        [POS_BITS-1:0]    r_position;
    logic                          r_eos;

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;

    // Pick the lowest pending result of the head entry
    always_comb begin
        pend = i_q_entry.ops & ~r_done;
        sel  = pend & (~pend + OP_BITS'(1));
        rest = pend & ~sel;
    end

    assign issue   = i_q_valid && s1_ready;
    assign o_q_pop = issue && (rest == '0);

    // Route operands for the selected result
    always_comb begin
        opa     = i_q_entry.smp;
        opb     = i_q_entry.first;
        opc     = i_q_entry.second;
        sel_pos = '0;
        sel_eos = 1'b1;
        if (sel[OP_MID]) begin
            opa     = i_q_entry.older;
            opb     = i_q_entry.newer;
            opc     = i_q_entry.smp;
            sel_pos = i_q_entry.pos - POS_BITS'(1);
            sel_eos = 1'b0;
        end else if (sel[OP_TAIL]) begin
            opa     = i_q_entry.newer;
            opb     = i_q_entry.smp;
            opc     = i_q_entry.first;
            sel_pos = i_q_entry.pos;
            sel_eos = 1'b0;
        end
        sum = SUM_BITS'(opa) + SUM_BITS'(opb) + SUM_BITS'(opc);
    end

    // Track issued results of the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (issue) begin
            r_done <= (rest == '0) ? '0 : (r_done | sel);
        end
    end

    // Sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_sum    <= sum;
            r_s1_pos <= sel_pos;
            r_s1_eos <= sel_eos;
        end
    end

    // Divide magnitude by 3, truncating toward zero, then restore sign
    always_comb begin
        abs_sum    = r_sum[SUM_BITS-1] ? (~r_sum + SUM_BITS'(1)) : r_sum;
        mag        = abs_sum[MAG_BITS-1:0];
        prod       = PROD_BITS'(mag) * PROD_BITS'(RECIP);
        quot       = prod[RECIP_SHIFT +: SAMPLE_BITS];
        n_filtered = r_sum[SUM_BITS-1] ? (~quot + SAMPLE_BITS'(1)) : quot;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_filtered <= n_filtered;
            r_position <= r_s1_pos;
            r_eos      <= r_s1_eos;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered        = r_filtered;
    assign o_position        = r_position;
    assign o_end_of_sequence = r_eos;

endmodule

FILE: src/circular_three_point_average.sv
// ----------------------------------------------------------------------------
// circular_three_point_average: circular three point moving average
// Treats each sample sequence as periodic and gives every sample the mean of
// itself and its two neighbors, Q8.8, truncated toward zero.
// ----------------------------------------------------------------------------
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+--------------------------------------------
//  input    | i_valid | o_stall | i_sample, i_last_sample
//  output   | o_valid | i_stall | o_filtered, o_position, o_end_of_sequence
//
// One input item is taken per cycle while the work queue has room.
// Results leave one per cycle while i_stall is low, through the work queue,
// the sum stage and the output register; the final sample of a sequence
// yields up to three results.
// Reset clears the sequence state, the queue and the pipeline valids.
// o_stall rises only when the four entry work queue is full.
// ----------------------------------------------------------------------------
module circular_three_point_average (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [cta_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                   i_last_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cta_pkg::SAMPLE_BITS-1:0] o_filtered,
    output logic        [cta_pkg::POS_BITS-1:0]    o_position,
    output logic                                   o_end_of_sequence
);
    import cta_pkg::*;

    logic   push, full, q_valid, q_pop;
    t_entry push_entry, head_entry;

    assign o_stall = full;

    // Front: accept and classify items
    cta_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // Queue between front and back
    cta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // Back: compute and deliver results
    cta_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_entry         (head_entry),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_filtered        (o_filtered),
        .o_position        (o_position),
        .o_end_of_sequence (o_end_of_sequence)
    );

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Never push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    // The closing result of a sequence is always g[0]
    a_eos_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_sequence) |-> (o_position == '0))
        else $error("end of sequence result not at position zero");

    // Every queued entry asks for at least one result
    a_entry_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (head_entry.ops != '0))
        else $error("queued entry carries no result");

endmodule
